// ===== rtl/ipt_pkg.sv =====
// Package for the in-order playout tracker: word types, field widths,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package ipt_pkg;

  localparam int SEQ_W      = 10;  // sequence number field
  localparam int TS_W       = 32;  // timestamp fields on the ports
  localparam int POS_W      = 11;  // positions, head and final index
  localparam int DUR_W      = 20;  // play duration register
  localparam int WORD_W     = 32;  // bitmap bits per memory row
  localparam int OFF_W      = 5;   // bit offset inside a row
  localparam int RUN_W      = 6;   // run of set bits, 0 .. WORD_W
  localparam int PROD_W     = RUN_W + DUR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_DURATION = 1'd1;

  localparam logic [POS_W-1:0] TOTAL_RST = 11'd1000;
  localparam logic [DUR_W-1:0] DUR_RST   = 20'd2730;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  arrival_time;
  } ipt_in_t;

  typedef struct packed {
    logic [SEQ_W-1:0] play_head;
    logic             started;
    logic [TS_W-1:0]  play_end_time;
    logic [TS_W-1:0]  stall_total;
    logic             finished;
    logic [TS_W-1:0]  finish_time;
    logic [TS_W-1:0]  first_arrival_time;
    logic [TS_W-1:0]  final_arrival_time;
    logic             out_of_range;
  } ipt_res_t;

  // classified word handed from the front to the back
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  arrival_time;
    logic             oor;
    logic             is_first;
    logic             is_last;
    logic [POS_W-1:0] last;
    logic [DUR_W-1:0] dur;
  } ipt_item_t;

endpackage

// ===== rtl/ipt_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/ipt_fifo.sv =====
// Two-entry queue of classified words between the front and the back.
// Depends on ipt_pkg.
`timescale 1ns / 1ps

module ipt_fifo
  import ipt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ipt_item_t push_item_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output ipt_item_t item_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  ipt_item_t         slot_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW:0]       count_q, count_d;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/ipt_front.sv =====
// Front end: configuration registers, input acceptance and range check.
// Depends on ipt_pkg.
`timescale 1ns / 1ps

module ipt_front
  import ipt_pkg::*;
#(
  parameter int MAX_PACKETS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  start,
  input  ipt_in_t               in_i,
  input  logic                  q_full_i,
  input  logic                  clearing_i,
  output logic                  busy,
  output logic                  push_o,
  output ipt_item_t             item_o
);

  logic [POS_W-1:0] total_q;
  logic [DUR_W-1:0] dur_q;
  logic [POS_W-1:0] eff_total;
  logic [POS_W-1:0] seq_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
      dur_q   <= DUR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOTAL_PACKETS: total_q <= cfg_data_i[POS_W-1:0];
        CFG_PLAY_DURATION: dur_q   <= cfg_data_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // a total above capacity is clipped to capacity
  assign eff_total = (32'(total_q) > 32'(MAX_PACKETS)) ? POS_W'(MAX_PACKETS) : total_q;
  assign seq_ext   = POS_W'(in_i.seq);

  assign busy   = q_full_i | clearing_i;
  assign push_o = start & ~busy;

  always_comb begin
    item_o.seq          = in_i.seq;
    item_o.arrival_time = in_i.arrival_time;
    item_o.oor          = (seq_ext >= eff_total);
    item_o.last         = eff_total - 1'b1;
    item_o.is_first     = (in_i.seq == '0);
    item_o.is_last      = (seq_ext == (eff_total - 1'b1));
    item_o.dur          = dur_q;
  end

endmodule

// ===== rtl/ipt_back.sv =====
// Back end: bitmap memory, clearing pass, head advance and bitmap walk.
// Depends on ipt_pkg and ipt_ram.
`timescale 1ns / 1ps

module ipt_back
  import ipt_pkg::*;
#(
  parameter int MAX_PACKETS = 1024,
  parameter int TIME_BITS   = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  ipt_item_t q_item_i,
  output logic      q_pop_o,
  output logic      clearing_o,
  output logic      res_valid_o,
  output ipt_res_t  res_o
);

  // only positions below 2048 can ever be addressed
  localparam int MAP_BITS = (MAX_PACKETS < 2048) ? MAX_PACKETS : 2048;
  localparam int ROWS_RAW = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int ROWS     = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
  localparam int ROW_AW   = $clog2(ROWS);
  localparam int SUM_W    = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MARK = 4'd2;
  localparam logic [3:0] S_ADV1 = 4'd3;
  localparam logic [3:0] S_ADV2 = 4'd4;
  localparam logic [3:0] S_WRD  = 4'd5;
  localparam logic [3:0] S_WRUN = 4'd6;
  localparam logic [3:0] S_WMUL = 4'd7;
  localparam logic [3:0] S_WADD = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + b;
    return (s > SUM_W'(TMAX)) ? TMAX : TIME_BITS'(s);
  endfunction

  function automatic logic [ROW_AW-1:0] row_of(input logic [POS_W-1:0] pos);
    return ROW_AW'(pos >> OFF_W);
  endfunction

  logic [3:0]           state_q, state_d;
  logic [ROW_AW-1:0]    clr_cnt_q, clr_cnt_d;
  ipt_item_t            item_q, item_d;
  logic [POS_W-1:0]     head_q, head_d;
  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] pe_q, pe_d;
  logic [TIME_BITS-1:0] stall_q, stall_d;
  logic [TIME_BITS-1:0] fin_at_q, fin_at_d;
  logic                 fin_seen_q, fin_seen_d;
  logic [TS_W-1:0]      first_q, first_d;
  logic [TS_W-1:0]      final_q, final_d;
  logic [TIME_BITS-1:0] diff_q, diff_d;
  logic [TIME_BITS-1:0] base_q, base_d;
  logic [POS_W-1:0]     rem_q, rem_d;
  logic [OFF_W-1:0]     off_q, off_d;
  logic [RUN_W-1:0]     run_q, run_d;
  logic [RUN_W-1:0]     k_q, k_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic                 cont_q, cont_d;
  logic                 res_valid_q, res_valid_d;
  ipt_res_t             res_q, res_d;

  logic                 ram_we;
  logic [ROW_AW-1:0]    ram_addr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;

  logic [TIME_BITS-1:0] t_arr;
  logic [POS_W-1:0]     next_pos;
  logic [WORD_W-1:0]    shifted;
  logic [RUN_W-1:0]     run_c;
  logic [RUN_W-1:0]     word_left;
  logic [RUN_W-1:0]     k_c;
  logic                 run_short;

  ipt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign t_arr     = TIME_BITS'(item_q.arrival_time);
  assign next_pos  = head_q + 1'b1;
  assign shifted   = ram_rdata >> off_q;
  assign word_left = RUN_W'(WORD_W) - RUN_W'(off_q);
  assign run_short = (POS_W'(run_q) < rem_q);
  assign k_c       = run_short ? run_q : RUN_W'(rem_q);

  // length of the run of set bits from the offset; zeros shift in above
  always_comb begin
    run_c = RUN_W'(WORD_W);
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!shifted[i]) begin
        run_c = RUN_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    item_d      = item_q;
    head_d      = head_q;
    valid_d     = valid_q;
    pe_d        = pe_q;
    stall_d     = stall_q;
    fin_at_d    = fin_at_q;
    fin_seen_d  = fin_seen_q;
    first_d     = first_q;
    final_d     = final_q;
    diff_d      = diff_q;
    base_d      = base_q;
    rem_d       = rem_q;
    off_d       = off_q;
    run_d       = run_q;
    k_d         = k_q;
    prod_d      = prod_q;
    cont_d      = cont_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = row_of(next_pos);
    ram_wdata   = '0;

    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ROW_AW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_addr = row_of(POS_W'(q_item_i.seq));
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          state_d = q_item_i.oor ? S_EMIT : S_MARK;
        end
      end
      S_MARK: begin
        // read-modify-write of the row that holds this sequence number
        ram_we    = 1'b1;
        ram_addr  = row_of(POS_W'(item_q.seq));
        ram_wdata = ram_rdata | (WORD_W'(1) << item_q.seq[OFF_W-1:0]);
        if (item_q.is_first) begin
          first_d = TS_W'(t_arr);
        end
        if (item_q.is_last) begin
          final_d = TS_W'(t_arr);
        end
        if (valid_q ? (POS_W'(item_q.seq) == next_pos) : (item_q.seq == '0)) begin
          state_d = S_ADV1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_ADV1: begin
        diff_d  = (t_arr > pe_q) ? (t_arr - pe_q) : '0;
        base_d  = (t_arr > pe_q) ? t_arr : pe_q;
        state_d = S_ADV2;
      end
      S_ADV2: begin
        stall_d = sat_add(stall_q, SUM_W'(diff_q));
        pe_d    = sat_add(base_q, SUM_W'(item_q.dur));
        head_d  = POS_W'(item_q.seq);
        valid_d = 1'b1;
        state_d = S_WRD;
      end
      S_WRD: begin
        if (head_q < item_q.last) begin
          off_d   = next_pos[OFF_W-1:0];
          rem_d   = item_q.last - head_q;
          state_d = S_WRUN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_WRUN: begin
        run_d   = run_c;
        state_d = S_WMUL;
      end
      S_WMUL: begin
        k_d    = k_c;
        prod_d = PROD_W'(k_c) * PROD_W'(item_q.dur);
        // carry on only if the run filled the rest of the row
        cont_d  = run_short && (run_q == word_left);
        state_d = S_WADD;
      end
      S_WADD: begin
        pe_d    = sat_add(pe_q, SUM_W'(prod_q));
        head_d  = head_q + POS_W'(k_q);
        state_d = cont_q ? S_WRD : S_FIN;
      end
      S_FIN: begin
        if (head_q == item_q.last) begin
          fin_at_d   = pe_q;
          fin_seen_d = 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        res_valid_d              = 1'b1;
        res_d.play_head          = head_q[SEQ_W-1:0];
        res_d.started            = valid_q;
        res_d.play_end_time      = TS_W'(pe_q);
        res_d.stall_total        = (64'(stall_q) > 64'hFFFF_FFFF) ? '1 : TS_W'(stall_q);
        res_d.finished           = fin_seen_q;
        res_d.finish_time        = TS_W'(fin_at_q);
        res_d.first_arrival_time = first_q;
        res_d.final_arrival_time = final_q;
        res_d.out_of_range       = item_q.oor;
        state_d                  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      head_q      <= '0;
      valid_q     <= 1'b0;
      pe_q        <= '0;
      stall_q     <= '0;
      fin_at_q    <= '0;
      fin_seen_q  <= 1'b0;
      first_q     <= '0;
      final_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      head_q      <= head_d;
      valid_q     <= valid_d;
      pe_q        <= pe_d;
      stall_q     <= stall_d;
      fin_at_q    <= fin_at_d;
      fin_seen_q  <= fin_seen_d;
      first_q     <= first_d;
      final_q     <= final_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    diff_q <= diff_d;
    base_q <= base_d;
    rem_q  <= rem_d;
    off_q  <= off_d;
    run_q  <= run_d;
    k_q    <= k_d;
    prod_q <= prod_d;
    cont_q <= cont_d;
  end

  assign clearing_o  = (state_q == S_CLR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/inorder_playout_tracker.sv =====
// Top level of the in-order playout tracker: front, queue and back.
// Depends on ipt_pkg, ipt_front, ipt_fifo, ipt_back.
`timescale 1ns / 1ps

//  channel   signals                                  direction  handshake
//  input     start, busy, in_i                        in         start && !busy
//  result    res_valid_o, res_o                       out        one-cycle strobe
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,   in         valid && ready
//            cfg_data_i
//
//  A word is taken into a two-entry queue; the back end handles one word at a time.
//  After a word is accepted with the back end idle, an out-of-range word goes straight
//  to the result; otherwise its bit is set in the bitmap and, when the head advances,
//  the bitmap is walked row by row until a zero bit or the final index is met.
//  After reset a clearing pass over all ceil(min(MAX_PACKETS,2048)/32) rows (at least 2)
//  holds busy high. The receiver cannot stall; busy rises while the queue is full.

module inorder_playout_tracker
  import ipt_pkg::*;
#(
  parameter int MAX_PACKETS = 1024,
  parameter int TIME_BITS   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ipt_in_t               in_i,
  output logic                  res_valid_o,
  output ipt_res_t              res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic      push;
  ipt_item_t push_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  ipt_item_t q_item;
  logic      clearing;

  assign cfg_ready_o = 1'b1;

  ipt_front #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .busy        (busy),
    .push_o      (push),
    .item_o      (push_item)
  );

  ipt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .item_o      (q_item)
  );

  ipt_back #(
    .MAX_PACKETS (MAX_PACKETS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/ipt_checker.sv =====
// Port-level checks for the in-order playout tracker, bound to the top level.
// Depends on ipt_pkg and inorder_playout_tracker.
`timescale 1ns / 1ps

module ipt_checker
  import ipt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     busy,
  input logic     res_valid_o,
  input ipt_res_t res_o
);

  // result strobes never come back to back; the back end returns to idle after each result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back-to-back result strobes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.started) |-> (res_o.play_head == '0 && !res_o.finished))
    else $error("head moved or finish seen before playback start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && $past(res_o.finished)) |-> res_o.finished)
    else $error("finished flag dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.stall_total >= $past(res_o.stall_total)))
    else $error("stall total decreased");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy)
    else $error("input taken during bitmap clearing");

endmodule

bind inorder_playout_tracker ipt_checker u_ipt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
